FILE: rtl/core/shcb_pkg.sv
// ----------------------------------------------------------------------------
// shcb_pkg
// Widths, limits and the stored-cluster entry type for the hit cluster builder.
// ----------------------------------------------------------------------------
package shcb_pkg;

  localparam int STRAW_W    = 7;
  localparam int TIME_W     = 16;
  localparam int POS_W      = 15;
  localparam int RES_W      = 12;
  localparam int TALLY_W    = 7;
  localparam int CHI2_W     = 16;
  localparam int IDX_OUT_W  = 6;

  localparam int MAX_CLUSTERS_DEF = 64;
  localparam logic [CHI2_W-1:0] MAX_CHI2_RESET = 16'd256;

  localparam int STRAW_GAP      = 3;
  localparam int TIME_WINDOW    = 50 * 8;  // 50 ns in 1/8 ns
  localparam int CHI2_FRAC      = 4;       // max_chi2 carries 4 fraction bits
  localparam logic [TALLY_W-1:0] TALLY_MAX = 7'd127;

  typedef struct packed {
    logic [STRAW_W-1:0] straw;
    logic [TIME_W-1:0]  tstamp;
    logic [POS_W-1:0]   pos;
    logic [RES_W-1:0]   res;
    logic [TALLY_W-1:0] tally;
  } entry_t;

endpackage

FILE: rtl/core/shcb_ifs.sv
// ----------------------------------------------------------------------------
// shcb_ifs
// Valid/ready channels for hit items and cluster result items.
// ----------------------------------------------------------------------------
interface shcb_in_if
  import shcb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     panel_start;
  logic [STRAW_W-1:0]       straw_number;
  logic [TIME_W-1:0]        hit_time;
  logic signed [POS_W-1:0]  wire_position;
  logic [RES_W-1:0]         wire_resolution;

  modport source (
    output valid, panel_start, straw_number, hit_time, wire_position, wire_resolution,
    input  ready
  );
  modport sink (
    input  valid, panel_start, straw_number, hit_time, wire_position, wire_resolution,
    output ready
  );
endinterface

interface shcb_out_if
  import shcb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] cluster_index;
  logic                 opened_new;
  logic                 table_overflow;
  logic [TALLY_W-1:0]   cluster_size;

  modport source (
    output valid, cluster_index, opened_new, table_overflow, cluster_size,
    input  ready
  );
  modport sink (
    input  valid, cluster_index, opened_new, table_overflow, cluster_size,
    output ready
  );
endinterface

FILE: rtl/core/straw_hit_cluster_builder_core.sv
// ----------------------------------------------------------------------------
// straw_hit_cluster_builder_core
// Groups the hits of one panel into clusters, one result item per hit item.
// ----------------------------------------------------------------------------
// Usage: hit items enter on in_hit (valid/ready), one result item per hit
// leaves on out_res. cfg_wr_en/cfg_wr_data write max_chi2 while idle.
// in_hit.ready is high only while the sequencer is idle; one hit at a time.
// Stored clusters are scanned from index 0 through a single-port table with
// registered read. Each cluster scanned is read and loaded, then the straw
// and time tests run; when they pass, the chi-square test follows (three
// products through one shared 25x16 multiplier, then a compare). Each hit
// also passes through accept, resolution square and result load, plus an
// end-of-table check when no cluster matches.
// Result items sit in an output register; the next hit is accepted while a
// result waits. A new result waits in the sequencer until the output
// register is free, so a stalled receiver backs up into in_hit.ready.
// Reset (rst_n low, synchronous) empties the table, drops any pending
// result and restores max_chi2 to 256. Table contents need no clearing.
// ----------------------------------------------------------------------------
module straw_hit_cluster_builder_core
  import shcb_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CHI2_W-1:0]  cfg_wr_data,
  shcb_in_if.sink            in_hit,
  shcb_out_if.source         out_res
);

  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HSQ  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_LD   = 4'd3;
  localparam logic [3:0] S_SQ1  = 4'd4;
  localparam logic [3:0] S_SQ2  = 4'd5;
  localparam logic [3:0] S_SQ3  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  k_r;
  logic [CHI2_W-1:0] chi2_r;

  logic [STRAW_W-1:0] h_straw_r;
  logic [TIME_W-1:0]  h_time_r;
  logic [POS_W-1:0]   h_pos_r;
  logic [RES_W-1:0]   h_res_r;

  entry_t mem [MAX_CLUSTERS];
  entry_t rd_r;
  logic   wr_en_r;
  logic [IDX_W-1:0] wr_addr_r;
  entry_t wr_data_r;

  logic [23:0] hres2_r;
  logic [15:0] adw_r;
  logic [35:0] lhs_r;
  logic [24:0] sr_r;
  logic [40:0] rhs_r;

  logic [IDX_W-1:0]     res_idx_r;
  logic                 res_open_r;
  logic                 res_ovf_r;
  logic [TALLY_W-1:0]   res_size_r;

  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic                 out_open_r;
  logic                 out_ovf_r;
  logic [TALLY_W-1:0]   out_size_r;

  // shared multiplier
  logic [24:0] mul_a;
  logic [15:0] mul_b;
  logic [40:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_HSQ: begin
        mul_a = 25'(h_res_r);
        mul_b = 16'(h_res_r);
      end
      S_SQ1: begin
        mul_a = 25'(adw_r);
        mul_b = adw_r;
      end
      S_SQ2: begin
        mul_a = 25'(rd_r.res);
        mul_b = 16'(rd_r.res);
      end
      S_SQ3: begin
        mul_a = sr_r;
        mul_b = chi2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 41'(mul_a) * 41'(mul_b);

  // gate tests on the entry just read
  logic signed [7:0]  ds;
  logic signed [16:0] dt;
  logic [16:0]        adt;
  logic signed [15:0] dw;
  logic               gate_ok;
  logic [TALLY_W-1:0] tally_inc;
  logic               scan_more;
  logic               table_full;
  logic               out_free;
  logic [IDX_W+IDX_OUT_W-1:0] idx_ext;

  assign ds  = $signed({1'b0, h_straw_r}) - $signed({1'b0, rd_r.straw});
  assign dt  = $signed({1'b0, h_time_r}) - $signed({1'b0, rd_r.tstamp});
  assign adt = dt[16] ? 17'(-dt) : 17'(dt);
  assign dw  = $signed({h_pos_r[POS_W-1], h_pos_r}) - $signed({rd_r.pos[POS_W-1], rd_r.pos});
  assign gate_ok = (ds < STRAW_GAP) && (adt < 17'(TIME_WINDOW));
  assign tally_inc = (rd_r.tally < TALLY_MAX) ? rd_r.tally + 7'd1 : rd_r.tally;
  assign scan_more = k_r < count_r;
  assign table_full = count_r >= CNT_W'(MAX_CLUSTERS);
  assign out_free = !out_valid_r || out_res.ready;
  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx_r};

  assign in_hit.ready = (state_r == S_IDLE);

  assign out_res.valid          = out_valid_r;
  assign out_res.cluster_index  = out_idx_r;
  assign out_res.opened_new     = out_open_r;
  assign out_res.table_overflow = out_ovf_r;
  assign out_res.cluster_size   = out_size_r;

  // cluster table
  always_ff @(posedge clk) begin
    if (state_r == S_RD && scan_more) begin
      rd_r <= mem[k_r[IDX_W-1:0]];
    end
    if (state_r == S_DONE && out_free && wr_en_r) begin
      mem[wr_addr_r] <= wr_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      chi2_r      <= MAX_CHI2_RESET;
      out_valid_r <= 1'b0;
      wr_en_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        chi2_r <= cfg_wr_data;
      end
      if (out_valid_r && out_res.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_hit.valid) begin
            h_straw_r <= in_hit.straw_number;
            h_time_r  <= in_hit.hit_time;
            h_pos_r   <= in_hit.wire_position;
            h_res_r   <= in_hit.wire_resolution;
            if (in_hit.panel_start) begin
              count_r <= '0;
            end
            k_r     <= '0;
            state_r <= S_HSQ;
          end
        end
        S_HSQ: begin
          hres2_r <= mul_p[23:0];
          state_r <= S_RD;
        end
        S_RD: begin
          if (scan_more) begin
            state_r <= S_LD;
          end else if (table_full) begin
            wr_en_r    <= 1'b0;
            res_idx_r  <= '0;
            res_open_r <= 1'b0;
            res_ovf_r  <= 1'b1;
            res_size_r <= '0;
            state_r    <= S_DONE;
          end else begin
            wr_en_r          <= 1'b1;
            wr_addr_r        <= count_r[IDX_W-1:0];
            wr_data_r.straw  <= h_straw_r;
            wr_data_r.tstamp <= h_time_r;
            wr_data_r.pos    <= h_pos_r;
            wr_data_r.res    <= h_res_r;
            wr_data_r.tally  <= 7'd1;
            count_r          <= count_r + 1'b1;
            res_idx_r        <= count_r[IDX_W-1:0];
            res_open_r       <= 1'b1;
            res_ovf_r        <= 1'b0;
            res_size_r       <= 7'd1;
            state_r          <= S_DONE;
          end
        end
        S_LD: begin
          adw_r <= dw[15] ? 16'(-dw) : 16'(dw);
          if (gate_ok) begin
            state_r <= S_SQ1;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_SQ1: begin
          lhs_r   <= {mul_p[31:0], {CHI2_FRAC{1'b0}}};
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          sr_r    <= 25'(hres2_r) + 25'(mul_p[23:0]);
          state_r <= S_SQ3;
        end
        S_SQ3: begin
          rhs_r   <= mul_p;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (41'(lhs_r) < rhs_r) begin
            wr_en_r          <= 1'b1;
            wr_addr_r        <= k_r[IDX_W-1:0];
            wr_data_r.straw  <= h_straw_r;
            wr_data_r.tstamp <= h_time_r;
            wr_data_r.pos    <= h_pos_r;
            wr_data_r.res    <= h_res_r;
            wr_data_r.tally  <= tally_inc;
            res_idx_r        <= k_r[IDX_W-1:0];
            res_open_r       <= 1'b0;
            res_ovf_r        <= 1'b0;
            res_size_r       <= tally_inc;
            state_r          <= S_DONE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_ext[IDX_OUT_W-1:0];
            out_open_r  <= res_open_r;
            out_ovf_r   <= res_ovf_r;
            out_size_r  <= res_size_r;
            wr_en_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for straw_hit_cluster_builder_core. Hit items go in on a
// valid/ready channel with bursty gaps, and result items are drained by a
// receiver that stalls on its own pattern. A local cluster-table model predicts
// each result when its hit is accepted, and every result item is checked field
// by field. Directed tasks cover the straw, time and chi-square windows, the
// zero-resolution case, a full table, tally saturation and the max_chi2
// extremes. Random panels of correlated hits with some noise follow.
// ----------------------------------------------------------------------------
module testbench;
  import shcb_pkg::*;

  localparam int N_CLUSTERS = MAX_CLUSTERS_DEF;
  localparam int DRAIN_CYCLES = 3 + 6 * N_CLUSTERS + 13;
  localparam int STUCK_LIMIT = 5000;

  typedef struct packed {
    logic                    panel_start;
    logic [STRAW_W-1:0]      straw;
    logic [TIME_W-1:0]       t;
    logic signed [POS_W-1:0] pos;
    logic [RES_W-1:0]        res;
  } hit_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic                 opened;
    logic                 overflow;
    logic [TALLY_W-1:0]   size;
  } cluster_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CHI2_W-1:0] cfg_wr_data;

  shcb_in_if  in_hit ();
  shcb_out_if out_res ();

  straw_hit_cluster_builder_core #(
    .MAX_CLUSTERS(N_CLUSTERS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_hit     (in_hit),
    .out_res    (out_res)
  );

  // cluster table model
  logic [STRAW_W-1:0] last_straw [N_CLUSTERS];
  logic [TIME_W-1:0]  last_time  [N_CLUSTERS];
  int                 last_pos   [N_CLUSTERS];
  logic [RES_W-1:0]   last_res   [N_CLUSTERS];
  logic [TALLY_W-1:0] hit_tally  [N_CLUSTERS];
  int                 open_clusters;
  logic [CHI2_W-1:0]  chi2_limit;

  cluster_result_t expected_clusters[$];
  int mismatches;
  int burst_left;
  int gap_max;
  int stall_mode;
  int stuck_cycles;
  logic [15:0] ready_pattern;
  logic [5:0]  ready_phase;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic cluster_result_t predict_cluster(input hit_t h);
    cluster_result_t r;
    int k;
    int found;
    int ds;
    int dt;
    int dw;
    longint adw;
    longint lhs;
    longint rhs;
    found = -1;
    if (h.panel_start) open_clusters = 0;
    for (k = 0; k < open_clusters && found < 0; k++) begin
      ds = int'(h.straw) - int'(last_straw[k]);
      dt = int'(h.t) - int'(last_time[k]);
      dw = int'(h.pos) - last_pos[k];
      if (dt < 0) dt = -dt;
      adw = (dw < 0) ? -dw : dw;
      lhs = (adw * adw) << CHI2_FRAC;
      rhs = longint'(chi2_limit) * (longint'(h.res) * longint'(h.res) +
                                    longint'(last_res[k]) * longint'(last_res[k]));
      if (ds < STRAW_GAP && dt < TIME_WINDOW && lhs < rhs) found = k;
    end
    r = '0;
    if (found < 0 && open_clusters >= N_CLUSTERS) begin
      r.overflow = 1'b1;
      return r;
    end
    if (found < 0) begin
      found = open_clusters;
      open_clusters++;
      hit_tally[found] = TALLY_W'(1);
      r.opened = 1'b1;
    end else if (hit_tally[found] < TALLY_MAX) begin
      hit_tally[found] = hit_tally[found] + 1'b1;
    end
    last_straw[found] = h.straw;
    last_time[found]  = h.t;
    last_pos[found]   = int'(h.pos);
    last_res[found]   = h.res;
    r.index = IDX_OUT_W'(found);
    r.size  = hit_tally[found];
    return r;
  endfunction

  function automatic hit_t mk_hit(input int ps, input int straw, input int t,
                                  input int pos, input int res);
    hit_t h;
    h.panel_start = ps[0];
    h.straw = STRAW_W'(straw);
    h.t     = TIME_W'(t);
    h.pos   = POS_W'(pos);
    h.res   = RES_W'(res);
    return h;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic log_mismatch(input string what, input cluster_result_t want,
                              input cluster_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected idx %0d new %0d ovf %0d size %0d, got idx %0d new %0d ovf %0d size %0d",
               what, want.index, want.opened, want.overflow, want.size,
               got.index, got.opened, got.overflow, got.size);
  endtask

  task automatic send_hit(input hit_t h);
    int gap;
    cluster_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_hit.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_hit.valid           <= 1'b1;
    in_hit.panel_start     <= h.panel_start;
    in_hit.straw_number    <= h.straw;
    in_hit.hit_time        <= h.t;
    in_hit.wire_position   <= h.pos;
    in_hit.wire_resolution <= h.res;
    @(posedge clk);
    while (!in_hit.ready) @(posedge clk);
    want = predict_cluster(h);
    expected_clusters = {expected_clusters, want};
    burst_left--;
  endtask

  task automatic wait_drained();
    in_hit.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_clusters.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_chi2(input logic [CHI2_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    chi2_limit = v;
  endtask

  task automatic test_field_extremes();
    send_hit(mk_hit(1, 0, 0, -16384, 1));
    send_hit(mk_hit(0, 95, 65535, 16383, 4095));
    send_hit(mk_hit(0, 95, 65535, 16383, 4095));
    send_hit(mk_hit(0, 0, 0, -16384, 4095));
    send_hit(mk_hit(1, 64, 32768, 0, 2048));
    send_hit(mk_hit(0, 63, 32767, -1, 2047));
  endtask

  task automatic test_straw_window();
    send_hit(mk_hit(1, 40, 1000, 0, 8));
    send_hit(mk_hit(0, 42, 1000, 0, 8));
    send_hit(mk_hit(0, 45, 1000, 0, 8));
    send_hit(mk_hit(0, 10, 1000, 0, 8));
    send_hit(mk_hit(0, 47, 1000, 0, 8));
  endtask

  task automatic test_time_window();
    send_hit(mk_hit(1, 30, 10000, 0, 8));
    send_hit(mk_hit(0, 30, 10399, 0, 8));
    send_hit(mk_hit(0, 30, 10799, 0, 8));
    send_hit(mk_hit(0, 30, 10400, 0, 8));
    send_hit(mk_hit(0, 30, 10000, 0, 8));
  endtask

  task automatic test_chi2_limit();
    send_hit(mk_hit(1, 5, 500, 0, 1));
    send_hit(mk_hit(0, 5, 500, 5, 1));
    send_hit(mk_hit(0, 5, 500, 11, 1));
    // exact equality fails: 16*20^2 == 256*(3^2+4^2)
    send_hit(mk_hit(1, 5, 500, 0, 3));
    send_hit(mk_hit(0, 5, 500, 20, 4));
    send_hit(mk_hit(0, 5, 500, 19, 4));
    // both resolutions zero
    send_hit(mk_hit(1, 7, 700, 0, 0));
    send_hit(mk_hit(0, 7, 700, 0, 0));
    send_hit(mk_hit(0, 7, 700, 0, 1));
  endtask

  task automatic test_table_full();
    int k;
    send_hit(mk_hit(1, 10, 0, 0, 10));
    for (k = 1; k <= N_CLUSTERS; k++) send_hit(mk_hit(0, 10, k * 800, 0, 10));
    send_hit(mk_hit(0, 90, 100, -200, 10));
    send_hit(mk_hit(0, 10, 5 * 800 + 50, 3, 10));
    send_hit(mk_hit(1, 10, 100, 0, 10));
  endtask

  task automatic test_tally_saturation();
    int k;
    send_hit(mk_hit(1, 20, 2000, 100, 50));
    for (k = 0; k < 131; k++) send_hit(mk_hit(0, 20, 2000, 100, 50));
  endtask

  task automatic test_chi2_extremes();
    int k;
    set_max_chi2(16'd0);
    for (k = 0; k < 10; k++) send_hit(mk_hit(k == 0, 50, 3000, 0, 4095));
    set_max_chi2(16'hffff);
    for (k = 0; k < 10; k++)
      send_hit(mk_hit(k == 0, 50 + k % 3, 3000 + 30 * k, 2000 * (k % 5) - 4000, 1 + k));
  endtask

  task automatic test_random_panels(input int n_items);
    hit_t h;
    int sent;
    int panel_len;
    int i;
    int straw_walk;
    int t_base;
    int pos_walk;
    sent = 0;
    while (sent < n_items) begin
      panel_len  = $urandom_range(1, 60);
      straw_walk = $urandom_range(0, 95);
      t_base     = $urandom_range(0, 64000);
      pos_walk   = int'($urandom_range(0, 32767)) - 16384;
      for (i = 0; i < panel_len && sent < n_items; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          h.panel_start = ($urandom_range(0, 7) == 0);
          h.straw = STRAW_W'($urandom_range(0, 95));
          h.t     = TIME_W'($urandom);
          h.pos   = POS_W'($urandom);
          h.res   = RES_W'($urandom_range(1, 4095));
        end else begin
          if ($urandom_range(0, 3) == 0) straw_walk = $urandom_range(0, 95);
          else straw_walk = clamp(straw_walk + int'($urandom_range(0, 4)) - 2, 0, 95);
          pos_walk = clamp(pos_walk + int'($urandom_range(0, 400)) - 200, -16384, 16383);
          h.panel_start = (i == 0);
          h.straw = STRAW_W'(straw_walk);
          h.t     = TIME_W'(clamp(t_base + int'($urandom_range(0, 1200)), 0, 65535));
          h.pos   = POS_W'(pos_walk);
          if ($urandom_range(0, 29) == 0) h.res = '0;
          else if ($urandom_range(0, 4) == 0) h.res = RES_W'($urandom_range(1, 4095));
          else h.res = RES_W'($urandom_range(1, 300));
        end
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_hit(h);
        sent++;
      end
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      ready_pattern <= 16'h00ff;
      ready_phase   <= '0;
    end else begin
      ready_phase <= ready_phase + 1'b1;
      if (ready_phase == '0) ready_pattern <= 16'($urandom) | 16'h0001;
      else ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      case (stall_mode)
        0: begin
          out_res.ready <= 1'b1;
        end
        1: begin
          out_res.ready <= ready_pattern[0];
        end
        default: begin
          out_res.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    cluster_result_t got;
    cluster_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.index    = out_res.cluster_index;
      got.opened   = out_res.opened_new;
      got.overflow = out_res.table_overflow;
      got.size     = out_res.cluster_size;
      if (expected_clusters.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_clusters.pop_front();
        if (got !== want) log_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_hit.valid && in_hit.ready) || (out_res.valid && out_res.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    in_hit.valid           = 1'b0;
    in_hit.panel_start     = 1'b0;
    in_hit.straw_number    = '0;
    in_hit.hit_time        = '0;
    in_hit.wire_position   = '0;
    in_hit.wire_resolution = '0;
    open_clusters = 0;
    chi2_limit    = MAX_CHI2_RESET;
    mismatches    = 0;
    burst_left    = 0;
    gap_max       = 4;
    stall_mode    = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_straw_window();
    stall_mode = 2;
    test_time_window();
    test_chi2_limit();
    gap_max = 0;
    stall_mode = 0;
    test_table_full();
    gap_max = 6;
    stall_mode = 1;
    test_tally_saturation();
    test_chi2_extremes();

    set_max_chi2(MAX_CHI2_RESET);
    gap_max = 0;
    stall_mode = 0;
    test_random_panels(65);
    set_max_chi2(16'($urandom));
    gap_max = 6;
    stall_mode = 1;
    test_random_panels(65);
    set_max_chi2(16'd16);
    gap_max = 3;
    stall_mode = 2;
    test_random_panels(65);
    set_max_chi2(16'hffff);
    gap_max = 10;
    stall_mode = 1;
    test_random_panels(65);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_clusters.size() != 0) begin
      $display("%0d results never arrived", expected_clusters.size());
      mismatches += expected_clusters.size();
    end
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
